>>> hdl/icc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_pkg
// shared types and constants for the clamped image convolution block
// ----------------------------------------------------------------------------
package icc_pkg;
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned MaxKernelDef = 5;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 11;
  localparam int unsigned CoefW        = 20;
  localparam int unsigned PixW         = 8;
  localparam int unsigned CoordW       = 10;
  localparam int unsigned CoefIdxW     = 5;
  localparam int unsigned PixMax       = 255;

  localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRadius = 2'd2;

  localparam logic CmdCoef  = 1'b0;
  localparam logic CmdPixel = 1'b1;

  // job handed from the sequencer to the accumulator
  typedef struct packed {
    logic              start;
    logic              tap;
    logic              last_tap;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              flast;
  } mac_ctl_t;
endpackage

>>> hdl/icc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_mac
// multiply-accumulate of window taps, clamp and output register
// ----------------------------------------------------------------------------
module icc_mac (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  icc_pkg::mac_ctl_t         ctl_i,
  input  logic [icc_pkg::PixW-1:0]  pix_i,
  input  logic signed [icc_pkg::CoefW-1:0] coef_i,
  input  logic                      stall_i,
  output logic                      valid_o,
  output logic [icc_pkg::PixW-1:0]  out_pixel_o,
  output logic [icc_pkg::CoordW-1:0] out_x_o,
  output logic [icc_pkg::CoordW-1:0] out_y_o,
  output logic                      frame_last_o
);
  import icc_pkg::*;
  localparam int unsigned AccW = CoefW + PixW + 6;

  logic signed [CoefW+PixW:0] prod_q;
  logic                       prod_v_q, prod_last_q, prod_start_q;
  logic signed [AccW-1:0]     acc_q, acc_base;
  logic [CoordW-1:0]          x_q, y_q;
  logic                       fl_q;
  logic [PixW-1:0]            res;
  logic signed [AccW-1:0]     acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      prod_v_q <= ctl_i.tap;
      valid_o  <= (prod_v_q && prod_last_q) || (valid_o && stall_i);
    end
  end

  assign acc_base = prod_start_q ? '0 : acc_q;
  assign acc_d    = acc_base + AccW'(prod_q);

  always_comb begin
    if (acc_d > AccW'(signed'(PixMax * 4096))) res = PixW'(PixMax);
    else if (acc_d < 0) res = '0;
    else res = PixW'(acc_d >>> 12);
  end

  always_ff @(posedge clk_i) begin
    prod_q       <= $signed({1'b0, pix_i}) * coef_i;
    prod_last_q  <= ctl_i.last_tap;
    prod_start_q <= ctl_i.start;
    if (ctl_i.start) begin
      x_q  <= ctl_i.x;
      y_q  <= ctl_i.y;
      fl_q <= ctl_i.flast;
    end
    if (prod_v_q) acc_q <= acc_d;
    if (prod_v_q && prod_last_q) begin
      out_pixel_o  <= res;
      out_x_o      <= x_q;
      out_y_o      <= y_q;
      frame_last_o <= fl_q;
    end
  end
endmodule

>>> hdl/icc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_seq
// line store, coefficient table and tap sequencer
// ----------------------------------------------------------------------------
module icc_seq #(
  parameter int unsigned MAX_WIDTH  = icc_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = icc_pkg::MaxHeightDef,
  parameter int unsigned MAX_KERNEL = icc_pkg::MaxKernelDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [icc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [icc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic                          cmd_i,
  input  logic [icc_pkg::CoefIdxW-1:0]  coef_index_i,
  input  logic signed [icc_pkg::CoefW-1:0] coef_value_i,
  input  logic [icc_pkg::PixW-1:0]      pixel_i,
  input  logic                          res_busy_i,
  output icc_pkg::mac_ctl_t             ctl_o,
  output logic [icc_pkg::PixW-1:0]      pix_o,
  output logic signed [icc_pkg::CoefW-1:0] coef_o
);
  import icc_pkg::*;
  localparam int unsigned Taps  = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned TapW  = $clog2(Taps);
  localparam int unsigned KW    = $clog2(MAX_KERNEL);
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = $clog2(MAX_KERNEL * MAX_WIDTH);
  localparam int unsigned RMax  = (MAX_KERNEL - 1) / 2;
  localparam int unsigned DimW  = (XW > YW ? XW : YW) + 1;

  typedef enum logic [1:0] {SIdle, SWalk, SDrain} state_e;
  state_e state_q;

  logic [PixW-1:0]  line_mem [MAX_KERNEL*MAX_WIDTH];
  logic signed [CoefW-1:0] coef_mem [Taps];
  logic [Taps-1:0]  coef_ok_q;
  logic [PixW-1:0]  lrd_q;
  logic signed [CoefW-1:0] crd_q;
  logic             crd_ok_q;

  logic [CfgDataW-1:0] wcfg_q, hcfg_q;
  logic [1:0]          rcfg_q;
  logic [XW-1:0]       col_q;
  logic [YW-1:0]       row_q;
  logic [KW-1:0]       slot_q;
  logic [KW-1:0]       ti_q, tj_q, rs_q;
  logic [TapW-1:0]     tk_q;
  logic [XW-1:0]       bx_q;
  logic                first_q, rd_q, rdlast_q, rdfirst_q;
  logic [CoordW-1:0]   ox_q, oy_q;
  logic                ofl_q;

  logic [DimW-1:0] w_eff, h_eff;
  logic [KW-1:0]   r_eff, side;
  logic [XW-1:0]   x;
  logic [YW-1:0]   y;
  logic            accept, interior;

  always_comb begin
    if (wcfg_q == '0) w_eff = DimW'(1);
    else if (DimW'(wcfg_q) > DimW'(MAX_WIDTH)) w_eff = DimW'(MAX_WIDTH);
    else w_eff = DimW'(wcfg_q);
    if (hcfg_q == '0) h_eff = DimW'(1);
    else if (DimW'(hcfg_q) > DimW'(MAX_HEIGHT)) h_eff = DimW'(MAX_HEIGHT);
    else h_eff = DimW'(hcfg_q);
    r_eff = (32'(rcfg_q) > RMax) ? KW'(RMax) : KW'(rcfg_q);
    side  = KW'({r_eff, 1'b1});
    x = (DimW'(col_q) >= w_eff) ? XW'(w_eff - 1'b1) : col_q;
    y = (DimW'(row_q) >= h_eff) ? YW'(h_eff - 1'b1) : row_q;
    interior = (DimW'(x) >= DimW'({r_eff, 1'b0})) && (DimW'(y) >= DimW'({r_eff, 1'b0}));
  end

  assign stall_o = (state_q != SIdle);
  assign accept  = valid_i && !stall_o;

  logic [KW-1:0] slot_nx;
  assign slot_nx = (32'(slot_q) == MAX_KERNEL - 1) ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      wcfg_q    <= CfgDataW'(1024);
      hcfg_q    <= CfgDataW'(1024);
      rcfg_q    <= 2'd1;
      col_q     <= '0;
      row_q     <= '0;
      slot_q    <= '0;
      coef_ok_q <= '0;
      rd_q      <= 1'b0;
    end else begin
      rd_q <= (state_q == SWalk) && (!res_busy_i || !first_q);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgWidth:  wcfg_q <= cfg_data_i;
          CfgHeight: hcfg_q <= cfg_data_i;
          CfgRadius: rcfg_q <= cfg_data_i[1:0];
          default: ;
        endcase
        if (cfg_idx_i == CfgWidth || cfg_idx_i == CfgHeight || cfg_idx_i == CfgRadius) begin
          col_q  <= '0;
          row_q  <= '0;
          slot_q <= '0;
        end
      end
      unique case (state_q)
        SIdle: if (accept) begin
          if (cmd_i == CmdCoef) begin
            if (32'(coef_index_i) < Taps) coef_ok_q[TapW'(coef_index_i)] <= 1'b1;
          end else begin
            if (interior) begin
              state_q <= SWalk;
              ti_q    <= '0;
              tj_q    <= '0;
              tk_q    <= '0;
              first_q <= 1'b1;
              bx_q    <= XW'(x - XW'({r_eff, 1'b0}));
              // ring slot of the window's top row
              rs_q    <= (slot_q >= KW'({r_eff, 1'b0})) ? slot_q - KW'({r_eff, 1'b0})
                         : KW'(32'(slot_q) + MAX_KERNEL - 32'({r_eff, 1'b0}));
              ox_q    <= CoordW'(x - XW'(r_eff));
              oy_q    <= CoordW'(y - YW'(r_eff));
              ofl_q   <= (DimW'(x) == w_eff - 1'b1) && (DimW'(y) == h_eff - 1'b1);
            end
            if (DimW'(x) + 1'b1 >= w_eff) begin
              col_q <= '0;
              if (DimW'(y) + 1'b1 >= h_eff) begin
                row_q  <= '0;
                slot_q <= '0;
              end else begin
                row_q  <= y + 1'b1;
                slot_q <= slot_nx;
              end
            end else begin
              col_q <= x + 1'b1;
            end
          end
        end
        SWalk: if (!res_busy_i || !first_q) begin
          rdfirst_q <= first_q;
          first_q   <= 1'b0;
          rdlast_q  <= (ti_q == side - 1'b1) && (tj_q == side - 1'b1);
          tk_q      <= tk_q + 1'b1;
          if (tj_q == side - 1'b1) begin
            tj_q <= '0;
            ti_q <= ti_q + 1'b1;
            rs_q <= (32'(rs_q) == MAX_KERNEL - 1) ? '0 : rs_q + 1'b1;
            if (ti_q == side - 1'b1) state_q <= SDrain;
          end else begin
            tj_q <= tj_q + 1'b1;
          end
        end
        SDrain: if (!rd_q) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  logic [AW-1:0] waddr, raddr;
  assign waddr = AW'(32'(slot_q) * MAX_WIDTH + 32'(x));
  assign raddr = AW'(32'(rs_q) * MAX_WIDTH + 32'(bx_q) + 32'(tj_q));

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == CmdPixel) line_mem[waddr] <= pixel_i;
    if (accept && cmd_i == CmdCoef && 32'(coef_index_i) < Taps)
      coef_mem[TapW'(coef_index_i)] <= coef_value_i;
    lrd_q    <= line_mem[raddr];
    crd_q    <= coef_mem[tk_q];
    crd_ok_q <= coef_ok_q[tk_q];
  end

  assign ctl_o.start    = rd_q && rdfirst_q;
  assign ctl_o.tap      = rd_q;
  assign ctl_o.last_tap = rdlast_q;
  assign ctl_o.x        = ox_q;
  assign ctl_o.y        = oy_q;
  assign ctl_o.flast    = ofl_q;
  assign pix_o          = lrd_q;
  assign coef_o         = crd_ok_q ? crd_q : '0;
endmodule

>>> hdl/image_convolution_clamped_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_convolution_clamped_top
// streaming 2-d convolution with clamp to 0..255
// ----------------------------------------------------------------------------
// A coefficient word or a border pixel is taken while idle; a pixel that
// completes an interior window starts a walk of side*side taps, read one
// tap a cycle (the first waits out a stalled output) from the line store
// memory into a single shared multiply-accumulate. The finished result sits
// in an output register while the next word is taken.
module image_convolution_clamped_top #(
  parameter int unsigned MAX_WIDTH  = icc_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = icc_pkg::MaxHeightDef,
  parameter int unsigned MAX_KERNEL = icc_pkg::MaxKernelDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [icc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [icc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic                          cmd_i,
  input  logic [icc_pkg::CoefIdxW-1:0]  coef_index_i,
  input  logic signed [icc_pkg::CoefW-1:0] coef_value_i,
  input  logic [icc_pkg::PixW-1:0]      pixel_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [icc_pkg::PixW-1:0]      out_pixel_o,
  output logic [icc_pkg::CoordW-1:0]    out_x_o,
  output logic [icc_pkg::CoordW-1:0]    out_y_o,
  output logic                          frame_last_o
);
  import icc_pkg::*;
  mac_ctl_t ctl;
  logic [PixW-1:0] pix;
  logic signed [CoefW-1:0] coef;

  icc_seq #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_KERNEL(MAX_KERNEL)) u_seq (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .valid_i, .stall_o,
    .cmd_i, .coef_index_i, .coef_value_i, .pixel_i,
    .res_busy_i(valid_o && stall_i), .ctl_o(ctl), .pix_o(pix), .coef_o(coef)
  );

  icc_mac u_mac (
    .clk_i, .rst_ni, .ctl_i(ctl), .pix_i(pix), .coef_i(coef), .stall_i,
    .valid_o, .out_pixel_o, .out_x_o, .out_y_o, .frame_last_o
  );
endmodule
